// File: hw/rtl/dchm_pkg.sv
package dchm_pkg;

    localparam int unsigned DUAL_W   = 32;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned PW_W     = 24;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned RES_CAP  = 64;
    localparam logic [DUAL_W-1:0] DUAL_MAX = 32'h7FFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4096;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_START = 1'b1;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [PW_W-1:0]   pair_weight;
        logic [CNT_W-1:0]  vertex_count;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]  vertex;
        logic [IDX_W-1:0]  mate;
        logic              last;
        logic              timed_out;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MIN_RD,
        S_MIN_CMP,
        S_DINIT,
        S_STAGE,
        S_ROOT,
        S_DEQ,
        S_DEQ_W,
        S_SCAN_V1,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DL_I,
        S_DL_U,
        S_DL_RD,
        S_DL_EV,
        S_UPD_RD,
        S_UPD_WR,
        S_AUG_RD,
        S_AUG_EV,
        S_AUG_W2,
        S_FOLD_RD,
        S_FOLD_W1,
        S_FOLD_W2,
        S_OUT_RD,
        S_OUT_LD,
        S_TMO,
        S_OUT_WAIT
    } t_state;

endpackage

// File: hw/rtl/dchm_weights.sv
module dchm_weights
    import dchm_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [IDX_W-1:0]                     i_wrow,
    input  logic [IDX_W-1:0]                     i_wcol,
    input  logic [PW_W-1:0]                      i_wdata,
    input  logic                                 i_re,
    input  logic [$clog2(MAX_VERTICES)-1:0]      i_rrow,
    input  logic [$clog2(MAX_VERTICES)-1:0]      i_rcol,
    output logic [WEIGHT_BITS-1:0]               o_rdata
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DEPTH = 1 << (2 * VW);

    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [31:0]            wrow32;
    logic [31:0]            wcol32;
    logic [31:0]            wdat32;
    logic                   in_range;

    assign wrow32   = 32'(i_wrow);
    assign wcol32   = 32'(i_wcol);
    assign wdat32   = 32'(i_wdata);
    assign in_range = (wrow32 < 32'(MAX_VERTICES)) && (wcol32 < 32'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (i_we && in_range) begin
            r_mem[{wrow32[VW-1:0], wcol32[VW-1:0]}] <= wdat32[WEIGHT_BITS-1:0];
        end
        if (i_re) begin
            o_rdata <= r_mem[{i_rrow, i_rcol}];
        end
    end

endmodule

// File: hw/rtl/double_cover_hungarian_matcher_unit.sv
// Minimum-weight matcher on the double cover of up to MAX_VERTICES vertices.
// Input words arrive on i_in_valid / o_in_stall. A write word stores one pair
// weight and is taken at once while idle; a start word runs the primal-dual
// search over vertex_count vertices and keeps o_in_stall high until every
// result word of that run has been taken.
// Result words leave on o_out_valid / i_out_stall from an output register:
// one word per vertex in ascending order with last on the final one, or a
// single word with timed_out set when stage_limit stages pass unfinished.
// A start runs the minimum search over every pair, then per stage the
// breadth-first search and the dual update over the edges they examine, all
// bound by the registered read of the weight and dual stores.
// Each result word is read from the result store into the output register;
// while the receiver stalls the word is held and the search state is kept.
// Reset sets stage_limit to 4096 and returns the block to idle; stored
// weights are not cleared by reset and survive it.
module double_cover_hungarian_matcher_unit
    import dchm_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_word           o_out_word,
    input  logic                i_cfg_we,
    input  logic [LIMIT_W-1:0]  i_cfg_wdata
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = VW + 1;
    localparam int NCOPY = 1 << CW;
    localparam int NCAP  = (MAX_VERTICES < RES_CAP) ? MAX_VERTICES : RES_CAP;
    localparam int NW    = $clog2(NCAP + 1);
    localparam int QW    = $clog2(2 * NCAP + 1);

    t_state                 r_state, n_state;
    logic [NW-1:0]          r_n, n_n, r_i, n_i, r_j, n_j, r_d, n_d;
    logic                   r_k, n_k, r_add, n_add;
    logic [QW-1:0]          r_head, n_head, r_tail, n_tail, r_mcnt, n_mcnt;
    logic [CW-1:0]          r_v1, n_v1, r_mv1, n_mv1, r_cur, n_cur, r_p, n_p;
    logic [DUAL_W-1:0]      r_dv1, n_dv1, r_minw, n_minw, r_delta, n_delta, r_du, n_du;
    logic [LIMIT_W-1:0]     r_stages, n_stages, r_limit;
    logic [NCOPY-1:0]       r_lab_s, n_lab_s, r_lab_t, n_lab_t, r_matched, n_matched;
    logic [VW-1:0]          r_jv, n_jv;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out, n_out;

    logic [DUAL_W-1:0]      r_dual [NCOPY];
    logic [CW-1:0]          r_pred [NCOPY];
    logic [CW-1:0]          r_mate [NCOPY];
    logic [CW-1:0]          r_queue [NCOPY];
    logic [VW-1:0]          r_res [1 << VW];

    logic                   du_re, du_we, pr_re, pr_we, mt_re, mt_we, q_re, q_we;
    logic                   rs_re, rs_we, w_re, w_we;
    logic [CW-1:0]          du_ra, du_wa, pr_ra, pr_wa, pr_wd, mt_ra, mt_wa, mt_wd;
    logic [CW-1:0]          q_ra, q_wa, q_wd;
    logic [DUAL_W-1:0]      du_wd, du_rd;
    logic [CW-1:0]          pr_rd, mt_rd, q_rd;
    logic [VW-1:0]          rs_ra, rs_wa, rs_wd, rs_rd;
    logic [VW-1:0]          w_rrow, w_rcol;
    logic [WEIGHT_BITS-1:0] w_rd;

    logic [DUAL_W-1:0]      w32, slack_scan, slack_dl;
    logic [CW-1:0]          v2, c_i, c_j, c_d;
    logic [NW-1:0]          start_n;
    logic                   mk_t, mk_s, v1_mated;

    dchm_weights #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_wrow  (i_in_word.row_index),
        .i_wcol  (i_in_word.col_index),
        .i_wdata (i_in_word.pair_weight),
        .i_re    (w_re),
        .i_rrow  (w_rrow),
        .i_rcol  (w_rcol),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (du_we) begin
            r_dual[du_wa] <= du_wd;
        end
        if (du_re) begin
            du_rd <= r_dual[du_ra];
        end
        if (pr_we) begin
            r_pred[pr_wa] <= pr_wd;
        end
        if (pr_re) begin
            pr_rd <= r_pred[pr_ra];
        end
        if (mt_we) begin
            r_mate[mt_wa] <= mt_wd;
        end
        if (mt_re) begin
            mt_rd <= r_mate[mt_ra];
        end
        if (q_we) begin
            r_queue[q_wa] <= q_wd;
        end
        if (q_re) begin
            q_rd <= r_queue[q_ra];
        end
        if (rs_we) begin
            r_res[rs_wa] <= rs_wd;
        end
        if (rs_re) begin
            rs_rd <= r_res[rs_ra];
        end
    end

    assign w32        = DUAL_W'(w_rd);
    assign slack_scan = w32 - r_dv1 - du_rd;
    assign slack_dl   = w32 - r_du - du_rd;
    assign v2         = {~r_v1[CW-1], VW'(r_d)};
    assign c_i        = {1'b0, VW'(r_i)};
    assign c_j        = {1'b1, VW'(r_j)};
    assign c_d        = {r_k, VW'(r_d)};
    assign start_n    = (i_in_word.vertex_count > CNT_W'(NCAP)) ? NW'(NCAP)
                                                               : NW'(i_in_word.vertex_count);
    assign v1_mated   = r_matched[r_v1] && (r_mv1 == v2);
    assign mk_t       = r_lab_s[r_v1] && !v1_mated;
    assign mk_s       = r_lab_t[r_v1] && v1_mated;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state = r_state;
        n_n = r_n; n_i = r_i; n_j = r_j; n_d = r_d; n_k = r_k; n_add = r_add;
        n_head = r_head; n_tail = r_tail; n_mcnt = r_mcnt;
        n_v1 = r_v1; n_mv1 = r_mv1; n_cur = r_cur; n_p = r_p;
        n_dv1 = r_dv1; n_minw = r_minw; n_delta = r_delta; n_du = r_du;
        n_stages = r_stages;
        n_lab_s = r_lab_s; n_lab_t = r_lab_t; n_matched = r_matched;
        n_jv = r_jv; n_out_valid = r_out_valid; n_out = r_out;
        du_re = 1'b0; du_we = 1'b0; du_ra = '0; du_wa = '0; du_wd = '0;
        pr_re = 1'b0; pr_we = 1'b0; pr_ra = '0; pr_wa = '0; pr_wd = '0;
        mt_re = 1'b0; mt_we = 1'b0; mt_ra = '0; mt_wa = '0; mt_wd = '0;
        q_re = 1'b0; q_we = 1'b0; q_ra = '0; q_wa = '0; q_wd = '0;
        rs_re = 1'b0; rs_we = 1'b0; rs_ra = '0; rs_wa = '0; rs_wd = '0;
        w_re = 1'b0; w_we = 1'b0; w_rrow = '0; w_rcol = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.action == ACT_WRITE) begin
                        w_we = 1'b1;
                    end else if (start_n != '0) begin
                        n_n       = start_n;
                        n_matched = '0;
                        n_mcnt    = '0;
                        n_stages  = '0;
                        n_minw    = DUAL_MAX;
                        n_i       = '0;
                        n_j       = NW'(1);
                        n_k       = 1'b0;
                        n_state   = (start_n < NW'(2)) ? S_DINIT : S_MIN_RD;
                    end
                end
            end
            S_MIN_RD: begin
                w_re = 1'b1; w_rrow = VW'(r_i); w_rcol = VW'(r_j);
                n_state = S_MIN_CMP;
            end
            S_MIN_CMP: begin
                if (w32 < r_minw) begin
                    n_minw = w32;
                end
                if (r_j + NW'(1) < r_n) begin
                    n_j = r_j + NW'(1);
                    n_state = S_MIN_RD;
                end else if (r_i + NW'(2) < r_n) begin
                    n_i = r_i + NW'(1);
                    n_j = r_i + NW'(2);
                    n_state = S_MIN_RD;
                end else begin
                    n_i = '0;
                    n_k = 1'b0;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                du_we = 1'b1;
                du_wa = {r_k, VW'(r_i)};
                du_wd = r_k ? '0 : r_minw;
                n_k = ~r_k;
                if (r_k) begin
                    if (r_i + NW'(1) == r_n) begin
                        n_state = S_STAGE;
                    end else begin
                        n_i = r_i + NW'(1);
                    end
                end
            end
            S_STAGE: begin
                if (r_mcnt == QW'({r_n, 1'b0})) begin
                    n_i = '0;
                    n_state = S_FOLD_RD;
                end else if (r_stages >= r_limit) begin
                    n_state = S_TMO;
                end else begin
                    n_stages = r_stages + LIMIT_W'(1);
                    n_lab_s = '0;
                    n_lab_t = '0;
                    n_d = '0;
                    n_head = '0;
                    n_tail = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (!r_matched[{1'b0, VW'(r_d)}]) begin
                    n_lab_s[{1'b0, VW'(r_d)}] = 1'b1;
                    q_we = 1'b1; q_wa = CW'(r_tail); q_wd = {1'b0, VW'(r_d)};
                    pr_we = 1'b1; pr_wa = {1'b0, VW'(r_d)}; pr_wd = {1'b0, VW'(r_d)};
                    n_tail = r_tail + QW'(1);
                end
                if (r_d + NW'(1) == r_n) begin
                    n_state = S_DEQ;
                end else begin
                    n_d = r_d + NW'(1);
                end
            end
            S_DEQ: begin
                if (r_head == r_tail) begin
                    n_delta = DUAL_MAX;
                    n_i = '0;
                    n_state = S_DL_I;
                end else begin
                    q_re = 1'b1; q_ra = CW'(r_head);
                    n_head = r_head + QW'(1);
                    n_state = S_DEQ_W;
                end
            end
            S_DEQ_W: begin
                n_v1 = q_rd;
                if (r_lab_t[q_rd] && !r_matched[q_rd]) begin
                    n_cur = q_rd;
                    n_add = 1'b1;
                    n_state = S_AUG_RD;
                end else begin
                    du_re = 1'b1; du_ra = q_rd;
                    mt_re = 1'b1; mt_ra = q_rd;
                    n_d = '0;
                    n_state = S_SCAN_V1;
                end
            end
            S_SCAN_V1: begin
                n_dv1 = du_rd;
                n_mv1 = mt_rd;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (r_d == r_n) begin
                    n_state = S_DEQ;
                end else if ((VW'(r_d) == r_v1[VW-1:0]) || r_lab_s[v2] || r_lab_t[v2]) begin
                    n_d = r_d + NW'(1);
                end else begin
                    w_re = 1'b1; w_rrow = r_v1[VW-1:0]; w_rcol = VW'(r_d);
                    du_re = 1'b1; du_ra = v2;
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if ((slack_scan == '0) && (mk_t || mk_s)) begin
                    if (mk_t) begin
                        n_lab_t[v2] = 1'b1;
                    end else begin
                        n_lab_s[v2] = 1'b1;
                    end
                    pr_we = 1'b1; pr_wa = v2; pr_wd = r_v1;
                    q_we = 1'b1; q_wa = CW'(r_tail); q_wd = v2;
                    n_tail = r_tail + QW'(1);
                end
                n_d = r_d + NW'(1);
                n_state = S_SCAN_RD;
            end
            S_DL_I: begin
                if (r_i == r_n) begin
                    n_d = '0;
                    n_k = 1'b0;
                    n_state = S_UPD_RD;
                end else if (!r_lab_s[c_i]) begin
                    n_i = r_i + NW'(1);
                end else begin
                    du_re = 1'b1; du_ra = c_i;
                    n_state = S_DL_U;
                end
            end
            S_DL_U: begin
                n_du = du_rd;
                if ($signed(du_rd) < $signed(r_delta)) begin
                    n_delta = du_rd;
                end
                n_j = '0;
                n_state = S_DL_RD;
            end
            S_DL_RD: begin
                if (r_j == r_n) begin
                    n_i = r_i + NW'(1);
                    n_state = S_DL_I;
                end else if ((r_j == r_i) || r_lab_s[c_j] || r_lab_t[c_j]) begin
                    n_j = r_j + NW'(1);
                end else begin
                    w_re = 1'b1; w_rrow = VW'(r_i); w_rcol = VW'(r_j);
                    du_re = 1'b1; du_ra = c_j;
                    n_state = S_DL_EV;
                end
            end
            S_DL_EV: begin
                if ($signed(slack_dl) < $signed(r_delta)) begin
                    n_delta = slack_dl;
                end
                n_j = r_j + NW'(1);
                n_state = S_DL_RD;
            end
            S_UPD_RD: begin
                if (r_d == r_n) begin
                    n_state = S_STAGE;
                end else if (r_k ? r_lab_t[c_d] : r_lab_s[c_d]) begin
                    du_re = 1'b1; du_ra = c_d;
                    n_state = S_UPD_WR;
                end else begin
                    n_k = ~r_k;
                    if (r_k) begin
                        n_d = r_d + NW'(1);
                    end
                end
            end
            S_UPD_WR: begin
                du_we = 1'b1; du_wa = c_d;
                du_wd = r_k ? (du_rd - r_delta) : (du_rd + r_delta);
                n_k = ~r_k;
                if (r_k) begin
                    n_d = r_d + NW'(1);
                end
                n_state = S_UPD_RD;
            end
            S_AUG_RD: begin
                pr_re = 1'b1; pr_ra = r_cur;
                n_state = S_AUG_EV;
            end
            S_AUG_EV: begin
                if (pr_rd == r_cur) begin
                    n_mcnt = r_mcnt + QW'(2);
                    n_state = S_STAGE;
                end else if (r_add) begin
                    mt_we = 1'b1; mt_wa = r_cur; mt_wd = pr_rd;
                    n_matched[r_cur] = 1'b1;
                    n_p = pr_rd;
                    n_state = S_AUG_W2;
                end else begin
                    n_cur = pr_rd;
                    n_add = 1'b1;
                    n_state = S_AUG_RD;
                end
            end
            S_AUG_W2: begin
                mt_we = 1'b1; mt_wa = r_p; mt_wd = r_cur;
                n_matched[r_p] = 1'b1;
                n_cur = r_p;
                n_add = 1'b0;
                n_state = S_AUG_RD;
            end
            S_FOLD_RD: begin
                if (r_i == r_n) begin
                    n_d = '0;
                    n_state = S_OUT_RD;
                end else begin
                    mt_re = 1'b1; mt_ra = c_i;
                    n_state = S_FOLD_W1;
                end
            end
            S_FOLD_W1: begin
                n_jv = mt_rd[VW-1:0];
                rs_we = 1'b1; rs_wa = VW'(r_i); rs_wd = mt_rd[VW-1:0];
                n_state = S_FOLD_W2;
            end
            S_FOLD_W2: begin
                rs_we = 1'b1; rs_wa = r_jv; rs_wd = VW'(r_i);
                n_i = r_i + NW'(1);
                n_state = S_FOLD_RD;
            end
            S_OUT_RD: begin
                rs_re = 1'b1; rs_ra = VW'(r_d);
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out.vertex = IDX_W'(r_d);
                n_out.mate = IDX_W'(rs_rd);
                n_out.last = (r_d + NW'(1) == r_n);
                n_out.timed_out = 1'b0;
                n_state = S_OUT_WAIT;
            end
            S_TMO: begin
                n_out_valid = 1'b1;
                n_out.vertex = '0;
                n_out.mate = '0;
                n_out.last = 1'b1;
                n_out.timed_out = 1'b1;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_d = r_d + NW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
        r_n <= n_n; r_i <= n_i; r_j <= n_j; r_d <= n_d; r_k <= n_k; r_add <= n_add;
        r_head <= n_head; r_tail <= n_tail; r_mcnt <= n_mcnt;
        r_v1 <= n_v1; r_mv1 <= n_mv1; r_cur <= n_cur; r_p <= n_p;
        r_dv1 <= n_dv1; r_minw <= n_minw; r_delta <= n_delta; r_du <= n_du;
        r_stages <= n_stages;
        r_lab_s <= n_lab_s; r_lab_t <= n_lab_t; r_matched <= n_matched;
        r_jv <= n_jv; r_out <= n_out;
    end

endmodule

// File: hw/rtl/dchm_checker.sv
module dchm_port_props
    import dchm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  t_out_word           o_out_word
);

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("Result word dropped or changed while stalled.");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Input taken while a result word is pending.");

    a_timeout_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.timed_out) |->
        (o_out_word.last && (o_out_word.vertex == '0) && (o_out_word.mate == '0)))
        else $error("Timeout word is not a single empty final word.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("Block not idle after reset.");

endmodule

bind double_cover_hungarian_matcher_unit dchm_port_props u_dchm_port_props (.*);

// File: dv/dchm_checker.sv
`timescale 1ns / 1ps

module dchm_checker
    import dchm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_word           i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_word          i_out_word,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);

    localparam int NV = 64;
    localparam int NCOPY = 2 * NV;
    localparam int NO_MATE = 16'hFFFF;
    localparam int LBL_FREE = 0;
    localparam int LBL_S = 1;
    localparam int LBL_T = 2;

    bit [PW_W-1:0]    weights [NV*NV];
    bit [DUAL_W-1:0]  duals [NCOPY];
    int               labels [NCOPY];
    int               back_link [NCOPY];
    int               partner [NCOPY];
    bit               seen [NCOPY];
    int               bfs_queue [NCOPY];
    int               mate_list [RES_CAP];
    bit [LIMIT_W-1:0] stage_limit;
    t_out_word        mate_words [$];

    function automatic int vtx(int c);
        return (c >= NV) ? c - NV : c;
    endfunction

    function automatic int slack(int c1, int c2);
        bit [DUAL_W-1:0] s;
        s = DUAL_W'(weights[vtx(c1) * NV + vtx(c2)]) - duals[c1] - duals[c2];
        return int'(s);
    endfunction

    // Returns 1 when every copy got matched, 0 when the stage limit ran out.
    function automatic bit solve_matching(int n);
        bit [DUAL_W-1:0] minw;
        int matched, stages, head, tail, last_copy, v1, i1, v2, curr, steps, p;
        bit found, add, right;
        longint delta, u, s;
        minw = DUAL_MAX;
        matched = 0;
        stages = 0;
        for (int i = 0; i < NCOPY; i++) partner[i] = NO_MATE;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (DUAL_W'(weights[i * NV + j]) < minw) minw = DUAL_W'(weights[i * NV + j]);
        for (int i = 0; i < n; i++) begin
            duals[i] = minw;
            duals[NV + i] = '0;
        end
        while (matched < 2 * n) begin
            head = 0;
            tail = 0;
            last_copy = 0;
            found = 0;
            if (stages >= stage_limit) return 0;
            stages++;
            for (int i = 0; i < NCOPY; i++) begin
                labels[i] = LBL_FREE;
                seen[i] = 0;
            end
            for (int d = 0; d < n; d++) begin
                if (partner[d] == NO_MATE) begin
                    labels[d] = LBL_S;
                    bfs_queue[tail++] = d;
                    seen[d] = 1;
                    back_link[d] = d;
                end
            end
            while (head < tail) begin
                v1 = bfs_queue[head++];
                i1 = vtx(v1);
                right = (v1 >= NV);
                if (labels[v1] == LBL_T && partner[v1] == NO_MATE) begin
                    found = 1;
                    last_copy = v1;
                    break;
                end
                for (int d = 0; d < n; d++) begin
                    if (d == i1) continue;
                    v2 = right ? d : NV + d;
                    if (seen[v2]) continue;
                    if (slack(v1, v2) != 0) continue;
                    if (labels[v1] == LBL_S && labels[v2] == LBL_FREE && partner[v1] != v2)
                        labels[v2] = LBL_T;
                    if (labels[v1] == LBL_T && labels[v2] == LBL_FREE && partner[v1] == v2)
                        labels[v2] = LBL_S;
                    if (labels[v2] == LBL_FREE) continue;
                    if (tail >= NCOPY) continue;
                    back_link[v2] = v1;
                    bfs_queue[tail++] = v2;
                    seen[v2] = 1;
                end
            end
            if (found) begin
                curr = last_copy;
                steps = 0;
                add = 1;
                while (back_link[curr] != curr && steps < NCOPY) begin
                    p = back_link[curr];
                    if (add) begin
                        partner[curr] = p;
                        partner[p] = curr;
                    end
                    add = !add;
                    curr = p;
                    steps++;
                end
                matched = 0;
                for (int d = 0; d < n; d++) begin
                    if (partner[d] != NO_MATE) matched++;
                    if (partner[NV + d] != NO_MATE) matched++;
                end
            end else begin
                delta = 64'h7FFF_FFFF;
                for (int i = 0; i < n; i++) begin
                    if (labels[i] != LBL_S) continue;
                    u = int'(duals[i]);
                    if (u < delta) delta = u;
                    for (int j = 0; j < n; j++) begin
                        if (j == i || labels[NV + j] != LBL_FREE) continue;
                        s = slack(i, NV + j);
                        if (s < delta) delta = s;
                    end
                end
                for (int d = 0; d < n; d++) begin
                    if (labels[d] == LBL_S) duals[d] += delta[31:0];
                    if (labels[NV + d] == LBL_T) duals[NV + d] -= delta[31:0];
                end
            end
        end
        for (int i = 0; i < n; i++) mate_list[i] = 0;
        for (int i = 0; i < n; i++) begin
            if (partner[i] != NO_MATE && partner[i] < NCOPY) begin
                mate_list[i] = vtx(partner[i]);
                mate_list[vtx(partner[i])] = i;
            end
        end
        return 1;
    endfunction

    task automatic predict_word(t_in_word w);
        int n;
        t_out_word r;
        if (w.action == ACT_WRITE) begin
            weights[int'(w.row_index) * NV + int'(w.col_index)] = w.pair_weight;
            return;
        end
        n = w.vertex_count;
        if (n > NV) n = NV;
        if (n == 0) return;
        if (!solve_matching(n)) begin
            r = '{vertex: '0, mate: '0, last: 1'b1, timed_out: 1'b1};
            mate_words.insert(mate_words.size(), r);
            return;
        end
        for (int v = 0; v < n; v++) begin
            r.vertex = IDX_W'(v);
            r.mate = IDX_W'(mate_list[v]);
            r.last = (v + 1 == n);
            r.timed_out = 1'b0;
            mate_words.insert(mate_words.size(), r);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        stage_limit = LIMIT_RESET;
    end

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (!i_rst_n) begin
            stage_limit = LIMIT_RESET;
        end else begin
            if (i_cfg_we) stage_limit = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predict_word(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (mate_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result word %p", $realtime, i_out_word);
                end else begin
                    exp_word = mate_words[0];
                    mate_words.delete(0);
                    if (exp_word.vertex !== i_out_word.vertex || exp_word.mate !== i_out_word.mate
                        || exp_word.last !== i_out_word.last
                        || exp_word.timed_out !== i_out_word.timed_out) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch, expected %p, got %p", $realtime,
                                     exp_word, i_out_word);
                    end
                end
            end
        end
        o_pending = mate_words.size();
    end

    initial o_pending = 0;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import dchm_pkg::*;
;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_word          o_out_word;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;
    int runs_started;

    double_cover_hungarian_matcher_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    dchm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_word      (i_in_word),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_word     (o_out_word),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_in_word w);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
            @(negedge i_clk);
        end
        words_sent++;
    endtask

    task automatic write_weight(int row, int col, bit [PW_W-1:0] w);
        t_in_word x;
        x = '{action: ACT_WRITE, row_index: IDX_W'(row), col_index: IDX_W'(col),
              pair_weight: w, vertex_count: CNT_W'($urandom)};
        send_word(x);
    endtask

    task automatic start_run(int cnt);
        t_in_word x;
        x = '{action: ACT_START, row_index: IDX_W'($urandom), col_index: IDX_W'($urandom),
              pair_weight: PW_W'($urandom), vertex_count: CNT_W'(cnt)};
        send_word(x);
        runs_started++;
    endtask

    // Weight styles: 0 small ties, 1 full range, 2 all zero, 3 all maximum.
    task automatic load_weights(int n, int style);
        bit [PW_W-1:0] w;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                if (i == j) continue;
                case (style)
                    0: w = $urandom_range(6);
                    1: w = $urandom;
                    2: w = '0;
                    default: w = '1;
                endcase
                write_weight(i, j, w);
            end
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_limit(int lim);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= LIMIT_W'(lim);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_phase(int quota);
        int n;
        int lims [6] = '{1, 2, 5, 20, 60, 200};
        while (words_sent < quota) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(3, 7) : 2 * $urandom_range(1, 4);
            set_limit(lims[$urandom_range(5)]);
            load_weights(n, ($urandom_range(3) == 0) ? 1 : 0);
            if ($urandom_range(4) == 0) write_weight($urandom_range(63), $urandom_range(63),
                                                     PW_W'($urandom));
            start_run(n);
            if ($urandom_range(3) == 0) start_run($urandom_range(1, n));
            drain_block();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        words_sent = 0;
        runs_started = 0;
        send_idle_pct = 27;
        recv_idle_pct = 57;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_weight(63, 63, '1);
        write_weight(0, 63, 24'h5A5A5A);
        write_weight(63, 0, 24'hA5A5A5);
        start_run(0);
        drain_block();
        start_run(1);
        drain_block();
        set_limit(0);
        load_weights(2, 2);
        start_run(2);
        drain_block();
        set_limit(16'hFFFF);
        start_run(2);
        drain_block();
        load_weights(2, 3);
        start_run(2);
        drain_block();
        set_limit(1);
        load_weights(4, 1);
        start_run(4);
        drain_block();
        set_limit(100);
        load_weights(4, 0);
        start_run(4);
        drain_block();

        random_phase(60);
        send_idle_pct = 57;
        recv_idle_pct = 27;
        random_phase(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(160);

        $display("Sent %0d words over %0d matching runs; %0d result words checked.",
                 words_sent, runs_started, results_seen);
        $display("Runs covered empty, single vertex, odd counts, timeouts and idling mixes.");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(12 * 8_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
